### rtl/similarity_transform_residual_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for similarity_transform_residual
// Shorthand for clocked implication checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef SIMILARITY_TRANSFORM_RESIDUAL_ASSERT_SVH
`define SIMILARITY_TRANSFORM_RESIDUAL_ASSERT_SVH

// same-cycle implication
`define STR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/str_pkg.sv
// ----------------------------------------------------------------------------
// str_pkg
// Shared types, widths and register indexes of the residual block.
// ----------------------------------------------------------------------------
`default_nettype none

package str_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIST_W      = 32;
  localparam int ROT_W       = 48;
  localparam int ENT_W       = 16;
  localparam int TRANS_W     = 32;
  localparam int SCALE_W     = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int RAD_W       = 2 * DIST_W;
  localparam int SQRT_STEPS  = DIST_W;

  localparam int PROD_W = COORD_WIDTH + ENT_W;
  localparam int SUM_W  = COORD_WIDTH + ENT_W + 3;
  localparam int DOT_W  = SUM_W - 14;
  localparam int SCL_W  = DOT_W + SCALE_W + 1;
  localparam int MAP_W  = SCL_W + 2;
  localparam int DIFF_W = MAP_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT0  = 3'd0,
    CFG_ROT1  = 3'd1,
    CFG_ROT2  = 3'd2,
    CFG_TX    = 3'd3,
    CFG_TY    = 3'd4,
    CFG_TZ    = 3'd5,
    CFG_SCALE = 3'd6
  } str_cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] lhs_x;
    logic signed [COORD_WIDTH-1:0] lhs_y;
    logic signed [COORD_WIDTH-1:0] lhs_z;
    logic signed [COORD_WIDTH-1:0] rhs_x;
    logic signed [COORD_WIDTH-1:0] rhs_y;
    logic signed [COORD_WIDTH-1:0] rhs_z;
    logic                          last_in;
  } str_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
    logic              last_out;
  } str_out_t;

  // sideband that rides along the root pipeline
  typedef struct packed {
    logic sat;
    logic last;
  } str_side_t;

endpackage

`default_nettype wire

### rtl/similarity_transform_residual.sv
// Depth: 40 register stages (7 arithmetic, 32 square-root, one output).
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the default
// transform: rows 0 and 1 swap x and y, row 2 is zero, no translation, scale 1.0.
// ----------------------------------------------------------------------------
// similarity_transform_residual
// Residual distance of a 3D point pair under a configured similarity
// transform: |rhs - (s * R * lhs + t)|, unsigned Q16.16, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module similarity_transform_residual (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire str_pkg::str_in_t             in_data,
  output logic                              out_valid,
  output str_pkg::str_out_t                 out_data,
  input  wire logic                         cfg_we,
  input  wire logic [str_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [str_pkg::ROT_W-1:0]    cfg_data
);
  import str_pkg::*;

  // ---------------- configuration registers ----------------
  logic [ROT_W-1:0]          rot_r   [3];
  logic signed [TRANS_W-1:0] trans_r [3];
  logic [SCALE_W-1:0]        scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]   <= 48'h0000_4000_0000;
      rot_r[1]   <= 48'h0000_0000_4000;
      rot_r[2]   <= '0;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
      scale_r    <= 24'h01_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROT0:  rot_r[0]   <= cfg_data;
        CFG_ROT1:  rot_r[1]   <= cfg_data;
        CFG_ROT2:  rot_r[2]   <= cfg_data;
        CFG_TX:    trans_r[0] <= cfg_data[TRANS_W-1:0];
        CFG_TY:    trans_r[1] <= cfg_data[TRANS_W-1:0];
        CFG_TZ:    trans_r[2] <= cfg_data[TRANS_W-1:0];
        CFG_SCALE: scale_r    <= cfg_data[SCALE_W-1:0];
        default: ; // unused index: write dropped
      endcase
    end
  end

  // pipeline accepts every cycle
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic signed [COORD_WIDTH-1:0] lhs_in [3];
  logic signed [COORD_WIDTH-1:0] rhs_in [3];
  assign lhs_in[0] = in_data.lhs_x;
  assign lhs_in[1] = in_data.lhs_y;
  assign lhs_in[2] = in_data.lhs_z;
  assign rhs_in[0] = in_data.rhs_x;
  assign rhs_in[1] = in_data.rhs_y;
  assign rhs_in[2] = in_data.rhs_z;

  // ---------------- pipeline registers ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic l1_r, l2_r, l3_r, l4_r, l5_r, l6_r, l7_r;

  logic signed [PROD_W-1:0]      prod_r [3][3];
  logic signed [COORD_WIDTH-1:0] rhs1_r [3], rhs2_r [3], rhs3_r [3];
  logic signed [DOT_W-1:0]       dot_r  [3];
  logic signed [SCL_W-1:0]       scl_r  [3];
  logic signed [DIFF_W-1:0]      diff_r [3];
  logic [DIST_W-1:0]             mag_r  [3];
  logic                          ovf5_r [3];
  logic [RAD_W-1:0]              sq_r   [3];
  logic                          ovf6_r;
  logic [RAD_W-1:0]              rad_r;
  logic                          sat7_r;

  // ---------------- combinational stage logic ----------------
  logic signed [PROD_W-1:0]  prod_nxt [3][3];
  logic signed [SUM_W-1:0]   sum_w    [3];
  logic signed [DOT_W-1:0]   dot_nxt  [3];
  logic signed [SCL_W-1:0]   scl_nxt  [3];
  logic signed [MAP_W-1:0]   map_w    [3];
  logic signed [DIFF_W-1:0]  diff_nxt [3];
  logic [DIFF_W-1:0]         abs_w    [3];
  logic [DIST_W-1:0]         mag_nxt  [3];
  logic                      ovf_nxt  [3];
  logic [RAD_W-1:0]          sq_nxt   [3];
  logic [RAD_W+1:0]          tot_w;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      // S1: row x column products, exact Q.30
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = PROD_W'($signed(rot_r[r][ENT_W*c +: ENT_W]) * lhs_in[c]);
      end
      // S2: row sum, round half up to Q.16
      sum_w[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2])
               + SUM_W'(8192);
      dot_nxt[r] = DOT_W'(sum_w[r] >>> 14);
      // S3: scale multiply, Q.32
      scl_nxt[r] = SCL_W'(dot_r[r] * $signed({1'b0, scale_r}));
      // S4: round half up to Q.16, add translation, difference to target
      map_w[r] = MAP_W'((scl_r[r] + SCL_W'(32768)) >>> 16) + MAP_W'(trans_r[r]);
      diff_nxt[r] = DIFF_W'(rhs3_r[r]) - DIFF_W'(map_w[r]);
      // S5: magnitude, flag anything past 32 bits
      abs_w[r]   = diff_r[r][DIFF_W-1] ? DIFF_W'(-diff_r[r]) : DIFF_W'(diff_r[r]);
      ovf_nxt[r] = |abs_w[r][DIFF_W-1:DIST_W];
      mag_nxt[r] = abs_w[r][DIST_W-1:0];
      // S6: square, exact Q32.32
      sq_nxt[r] = mag_r[r] * mag_r[r];
    end
    // S7: sum of squares, two carry bits catch 2^64 and up
    tot_w = (RAD_W+2)'(sq_r[0]) + (RAD_W+2)'(sq_r[1]) + (RAD_W+2)'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
    l1_r <= in_data.last_in;
    l2_r <= l1_r;
    l3_r <= l2_r;
    l4_r <= l3_r;
    l5_r <= l4_r;
    l6_r <= l5_r;
    l7_r <= l6_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= prod_nxt[r][c];
      end
      rhs1_r[r] <= rhs_in[r];
      rhs2_r[r] <= rhs1_r[r];
      rhs3_r[r] <= rhs2_r[r];
      dot_r[r]  <= dot_nxt[r];
      scl_r[r]  <= scl_nxt[r];
      diff_r[r] <= diff_nxt[r];
      mag_r[r]  <= mag_nxt[r];
      ovf5_r[r] <= ovf_nxt[r];
      sq_r[r]   <= sq_nxt[r];
    end
    ovf6_r <= ovf5_r[0] | ovf5_r[1] | ovf5_r[2];
    rad_r  <= tot_w[RAD_W-1:0];
    sat7_r <= ovf6_r | (|tot_w[RAD_W+1:RAD_W]);
  end

  // ---------------- square root ----------------
  logic              sq_vld;
  logic [DIST_W-1:0] sq_root;
  str_side_t         sq_side;
  str_side_t         side7;

  assign side7.sat  = sat7_r;
  assign side7.last = l7_r;

  str_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v7_r),
    .in_rad   (rad_r),
    .in_side  (side7),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------- output register ----------------
  logic     out_valid_r;
  str_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_vld;
    end
    out_data_r.distance  <= sq_side.sat ? '1 : sq_root;
    out_data_r.saturated <= sq_side.sat;
    out_data_r.last_out  <= sq_side.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
`include "similarity_transform_residual_assert.svh"

  `STR_ASSERT_NXT(a_enter, accept, v1_r, "accepted item did not enter stage 1")
  `STR_ASSERT_IMP(a_sat_clamp, out_valid && out_data.saturated, out_data.distance == '1, "saturated result not clamped")
  `STR_ASSERT_NXT(a_out_follow, sq_vld, out_valid, "root result lost at output")

endmodule

`default_nettype wire

### rtl/str_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// str_sqrt_pipe
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module str_sqrt_pipe (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_vld,
  input  wire logic [str_pkg::RAD_W-1:0] in_rad,
  input  wire str_pkg::str_side_t      in_side,
  output logic                         out_vld,
  output logic [str_pkg::DIST_W-1:0]   out_root,
  output str_pkg::str_side_t           out_side
);
  import str_pkg::*;

  localparam int REM_W = DIST_W + 3;

  logic              vld_r  [SQRT_STEPS];
  logic [RAD_W-1:0]  rad_r  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [DIST_W-1:0] root_r [SQRT_STEPS];
  str_side_t         side_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic              vld_p;
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [DIST_W-1:0] root_p;
    str_side_t         side_p;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rad_p  = in_rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = in_side;
    end else begin : g_rest
      assign vld_p  = vld_r[i-1];
      assign rad_p  = rad_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign side_p = side_r[i-1];
    end

    // bring down two radicand bits, try (2*root)*2 + 1
    assign rem_sh = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_p;
      end
      rad_r[i]  <= {rad_p[RAD_W-3:0], 2'b00};
      rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[i] <= {root_p[DIST_W-2:0], ge};
      side_r[i] <= side_p;
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS-1];
  assign out_root = root_r[SQRT_STEPS-1];
  assign out_side = side_r[SQRT_STEPS-1];

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for similarity_transform_residual: point pairs
// are streamed in through the start/busy port and every residual is checked
// field by field against an in-bench fixed-point prediction, over several
// transform settings that include the register extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import str_pkg::*;

  localparam int PIPE_LAT    = 40;        // item to result strobe
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;  // no register here

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  str_in_t in_data;
  logic out_valid;
  str_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROT_W-1:0] cfg_data;

  similarity_transform_residual dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the transform registers
  logic [ROT_W-1:0] rot_m [3];
  logic signed [TRANS_W-1:0] trans_m [3];
  logic [SCALE_W-1:0] scale_m;

  str_in_t pair_q [$];        // items waiting to be driven
  str_out_t residual_q [$];   // predicted residuals, oldest first
  int mismatches;
  int cycles;
  bit taken;                  // item on the port was accepted at last edge
  bit calm;                   // no idling in the final stretch
  int gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction: rows rounded half up from Q.30 to Q.16, scaled and rounded
  // again, translated, then a floored integer square root of the squared sum.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic str_out_t residual_of(str_in_t p);
    longint lhs [3];
    longint rhs [3];
    longint acc_dot, dot, mapped, diff, ent;
    longint unsigned mag;
    logic [64:0] sumsq;
    bit sat;
    str_out_t res;
    lhs[0] = p.lhs_x; lhs[1] = p.lhs_y; lhs[2] = p.lhs_z;
    rhs[0] = p.rhs_x; rhs[1] = p.rhs_y; rhs[2] = p.rhs_z;
    sumsq = '0;
    sat = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc_dot = 0;
      for (int col = 0; col < 3; col++) begin
        ent = $signed(rot_m[row][16*col +: 16]);
        acc_dot += ent * lhs[col];
      end
      dot = (acc_dot + 8192) >>> 14;
      mapped = ((longint'(scale_m) * dot + 32768) >>> 16) + longint'(trans_m[row]);
      diff = rhs[row] - mapped;
      mag = (diff < 0) ? -diff : diff;
      if (mag > 64'hFFFF_FFFF) begin
        sat = 1'b1;
      end else begin
        sumsq = sumsq + 65'(mag * mag);
        if (sumsq[64]) sat = 1'b1;
      end
    end
    res.distance  = sat ? 32'hFFFF_FFFF : floor_sqrt(sumsq[63:0]);
    res.saturated = sat;
    res.last_out  = p.last_in;
    return res;
  endfunction

  task automatic report(string what, str_out_t got, str_out_t want);
    mismatches++;
    $display("[%0t] %s: got dist=%h sat=%b last=%b, want dist=%h sat=%b last=%b",
             $time, what, got.distance, got.saturated, got.last_out,
             want.distance, want.saturated, want.last_out);
  endtask

  // --------------------------------------------------------------------------
  // Sampling side: acceptance feeds the prediction, strobes are checked.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    str_out_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("similarity_transform_residual regression: fail");
      $finish;
    end
    taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (residual_q.size() == 0) begin
        want = '0;
        report("residual with none pending", out_data, want);
      end else begin
        want = residual_q.pop_front();
        if (out_data.distance !== want.distance) report("distance", out_data, want);
        if (out_data.saturated !== want.saturated) report("saturated", out_data, want);
        if (out_data.last_out !== want.last_out) report("last_out", out_data, want);
      end
    end
    if (rst_n && start && !busy) residual_q.push_back(residual_of(in_data));
  end

  // --------------------------------------------------------------------------
  // Driver: holds an item until accepted, otherwise idles in random bursts.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !taken) begin
      // held until the block takes it
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (pair_q.size() > 0) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        gap <= $urandom_range(1, 17) - 1;
        start <= 1'b0;
      end else begin
        in_data <= pair_q.pop_front();
        start <= 1'b1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ROT0, CFG_ROT1, CFG_ROT2: rot_m[idx] = val;
      CFG_TX, CFG_TY, CFG_TZ: trans_m[idx - CFG_TX] = val[TRANS_W-1:0];
      CFG_SCALE: scale_m = val[SCALE_W-1:0];
      default: ;  // unmapped index, write dropped
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait out every pending residual, plus the pipeline depth
  task automatic drain();
    wait (pair_q.size() == 0);
    wait (!start);
    wait (residual_q.size() == 0);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      2: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      3: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
      default: return 32'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  task automatic add_pair(logic [31:0] lx, ly, lz, rx, ry, rz, logic lst);
    str_in_t p;
    p.lhs_x = lx; p.lhs_y = ly; p.lhs_z = lz;
    p.rhs_x = rx; p.rhs_y = ry; p.rhs_z = rz;
    p.last_in = lst;
    pair_q.push_back(p);
  endtask

  // loose random pairs; with close set, most pairs put rhs near lhs so the
  // non-saturated root is exercised under an identity-like transform
  task automatic add_random(int n, bit close);
    logic [31:0] lx, ly, lz;
    for (int k = 0; k < n; k++) begin
      lx = pick_coord(); ly = pick_coord(); lz = pick_coord();
      if (close && $urandom_range(0, 3) != 0)
        add_pair(lx, ly, lz,
                 lx + 32'($signed($urandom_range(0, 8388608)) - 4194304),
                 ly + 32'($signed($urandom_range(0, 8388608)) - 4194304),
                 lz + 32'($signed($urandom_range(0, 65536)) - 32768),
                 1'($urandom_range(0, 1)));
      else
        add_pair(lx, ly, lz, pick_coord(), pick_coord(), pick_coord(),
                 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic logic [ROT_W-1:0] rand_row();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    rot_m[0] = 48'h0000_4000_0000;
    rot_m[1] = 48'h0000_0000_4000;
    rot_m[2] = '0;
    trans_m[0] = '0; trans_m[1] = '0; trans_m[2] = '0;
    scale_m = 24'h01_0000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset transform
    add_pair(0, 0, 0, 0, 0, 0, 1'b0);
    add_pair(0, 0, 0, 0, 0, 0, 1'b1);
    add_pair(32'h0001_0000, 32'h0002_0000, 0, 32'h0002_0000, 32'h0001_0000, 0, 1'b0);
    add_pair(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 1'b1);      // 3-4-5
    add_pair(0, 0, 0, 32'h0000_0001, 0, 0, 1'b0);                  // one lsb
    add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_pair(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 1'b0);      // diff 2^32-1
    add_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_pair(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1'b1);
    add_pair(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 1'b0);      // mapped == rhs
    drain();

    // identity rotation, small offsets: mostly real distances
    write_reg(CFG_ROT0, 48'h0000_0000_4000);
    write_reg(CFG_ROT1, 48'h0000_4000_0000);
    write_reg(CFG_ROT2, 48'h4000_0000_0000);
    write_reg(CFG_TX, 48'h0000_0000_8000);
    write_reg(CFG_TY, 48'h0000_FFFF_0000);
    write_reg(CFG_TZ, 48'h0000_0001_0000);
    add_pair(0, 0, 0, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
    add_random(300, 1'b1);
    drain();

    // fully random transform, wide writes exercise masking
    write_reg(CFG_ROT0, rand_row());
    write_reg(CFG_ROT1, rand_row());
    write_reg(CFG_ROT2, rand_row());
    write_reg(CFG_TX, rand_row());
    write_reg(CFG_TY, rand_row());
    write_reg(CFG_TZ, rand_row());
    write_reg(CFG_SCALE, rand_row());
    write_reg(CFG_UNUSED, rand_row());
    add_random(250, 1'b0);
    drain();

    // extremes: most negative entries, full scale, max x/z and min y translation
    write_reg(CFG_ROT0, 48'h8000_8000_8000);
    write_reg(CFG_ROT1, 48'h8000_8000_8000);
    write_reg(CFG_ROT2, 48'h8000_8000_8000);
    write_reg(CFG_TX, 48'h0000_7FFF_FFFF);
    write_reg(CFG_TY, 48'h0000_8000_0000);
    write_reg(CFG_TZ, 48'h0000_7FFF_FFFF);
    write_reg(CFG_SCALE, 48'h0000_00FF_FFFF);
    add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1'b1);
    add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1'b0);
    add_random(150, 1'b0);
    drain();

    // other extreme: max positive entries, zero scale, min x/z translation
    write_reg(CFG_ROT0, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_ROT1, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_ROT2, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_TX, 48'h0000_8000_0000);
    write_reg(CFG_TY, 48'h0000_0000_0000);
    write_reg(CFG_TZ, 48'h0000_8000_0000);
    write_reg(CFG_SCALE, 48'h0000_0000_0000);
    add_random(150, 1'b0);
    drain();

    // half-scale rotation mix with no translation, ends with no idling
    write_reg(CFG_ROT0, 48'h0000_2000_2000);
    write_reg(CFG_ROT1, 48'hE000_0000_2000);
    write_reg(CFG_ROT2, 48'h2000_E000_0000);
    write_reg(CFG_TX, 48'h0000_0000_0000);
    write_reg(CFG_TY, 48'h0000_0000_0000);
    write_reg(CFG_TZ, 48'h0000_0000_0000);
    write_reg(CFG_SCALE, 48'h0000_0001_8000);
    add_random(150, 1'b1);
    wait (pair_q.size() == 0);
    calm = 1'b1;
    add_random(150, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("similarity_transform_residual regression: pass");
    end else begin
      $display("similarity_transform_residual regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/str_pkg.sv
rtl/str_sqrt_pipe.sv
rtl/similarity_transform_residual.sv
tb/testbench.sv
